[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never comes true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_HOLDS(lbl, !(cond), msg)

`endif

[src/pscm_pkg.sv]
package pscm_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned MUL_W     = 2 * SAMPLE_W;
  localparam int unsigned PROD_W    = MUL_W - FRAC_BITS;   // shifted product
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLS = 2'd0,
    REG_NUM_ROWS = 2'd1,
    REG_CONJ     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a_slot0;
    logic signed [SAMPLE_W-1:0] a_slot1;
    logic signed [SAMPLE_W-1:0] b_slot0;
    logic signed [SAMPLE_W-1:0] b_slot1;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] c_slot0;
    logic signed [SAMPLE_W-1:0] c_slot1;
    logic        [POS_W-1:0]    out_row;
    logic        [POS_W-1:0]    out_col;
    logic                       run_last;
    logic                       frame_last;
  } out_beat_t;

  // Clip a widened sum to the Q1.30 sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

[src/pscm_prod_pair.sv]
// Two Q1.30 multiplies, each floored by 2^30 and registered.
module pscm_prod_pair
  import pscm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [SAMPLE_W-1:0] x0_i,
  input  logic signed [SAMPLE_W-1:0] y0_i,
  input  logic signed [SAMPLE_W-1:0] x1_i,
  input  logic signed [SAMPLE_W-1:0] y1_i,
  output logic signed [PROD_W-1:0]   p0_o,
  output logic signed [PROD_W-1:0]   p1_o
);

  logic signed [MUL_W-1:0]  full0, full1;
  logic signed [PROD_W-1:0] p0_q, p1_q;

  assign full0 = MUL_W'(x0_i) * MUL_W'(y0_i);
  assign full1 = MUL_W'(x1_i) * MUL_W'(y1_i);

  // Dropping the low fraction bits floors toward minus infinity.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= full0[MUL_W-1:FRAC_BITS];
      p1_q <= full1[MUL_W-1:FRAC_BITS];
    end
  end

  assign p0_o = p0_q;
  assign p1_o = p1_q;

endmodule

[src/packed_spectrum_complex_multiply.sv]
// Element-wise product of two packed 2D real-FFT spectra, A*B or A*conj(B) when
// conjugate_mode is set. Words of A and B arrive side by side in raster order,
// one beat per word pair, and the block tracks row and column itself from
// num_cols and num_rows (clamped to the MAX_COLS / MAX_ROWS range, rows taken
// as even). Column 0 of rows 0 and 1 is real DC/Nyquist data and each slot is
// multiplied on its own. Column 0 of an even row from row 2 on carries real
// parts: that beat is held and gives nothing; the following odd-row beat
// releases two result beats, the real row first, then the imaginary row.
// Throughput is one input beat per clock while the output does not stall; the
// other exception is the odd column-0 beat, which needs two passes through the
// four multipliers and so holds the input until its second pass issues. A
// result beat passes the issue register (loaded at acceptance), then the
// product register, then the result register; the imaginary-row beat of a
// pair follows the real-row beat.
// Products are floored by 2^30 and the sums saturate to 32 bits.
// Configuration is written through a plain write port and must only change
// while no beat is in flight.
`include "assert_macros.svh"

module packed_spectrum_complex_multiply
  import pscm_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input word pairs
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  // product words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o
);

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned CNT_W = (RW > CW) ? RW : CW;
  localparam int unsigned CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  typedef enum logic [1:0] {
    KIND_REAL,
    KIND_CPLX,
    KIND_PAIR
  } kind_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] num_cols_q, num_rows_q;
  logic             conj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= CFG_W'(1024);
      num_rows_q <= CFG_W'(1024);
      conj_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_COLS: num_cols_q <= cfg_data_i;
        REG_NUM_ROWS: num_rows_q <= cfg_data_i;
        REG_CONJ:     conj_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the frame geometry into the supported range.
  logic [CMP_W-1:0] ncols_raw, nrows_raw, ncols, nrows_clip, nrows;

  always_comb begin
    ncols_raw = CMP_W'(num_cols_q);
    nrows_raw = CMP_W'({num_rows_q[CFG_W-1:1], 1'b0});
    if (ncols_raw < CMP_W'(2)) begin
      ncols = CMP_W'(2);
    end else if (ncols_raw > CMP_W'(MAX_COLS)) begin
      ncols = CMP_W'(MAX_COLS);
    end else begin
      ncols = ncols_raw;
    end
    if (nrows_raw < CMP_W'(2)) begin
      nrows_clip = CMP_W'(2);
    end else if (nrows_raw > CMP_W'(MAX_ROWS)) begin
      nrows_clip = CMP_W'(MAX_ROWS);
    end else begin
      nrows_clip = nrows_raw;
    end
    nrows = {nrows_clip[CMP_W-1:1], 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Handshake across the three stages
  // ---------------------------------------------------------------------------
  logic i_valid_q, i_second_q, m_valid_q, o_valid_q;
  kind_e i_kind_q;
  logic in_acc, out_acc, o_ready, m_ready, m_load, o_load, i_done;

  assign out_acc = o_valid_q && !out_stall_i;
  assign o_ready = !o_valid_q || !out_stall_i;
  assign o_load  = m_valid_q && o_ready;
  assign m_ready = !m_valid_q || o_ready;
  assign m_load  = i_valid_q && m_ready;
  // The issue stage frees once its last beat moves on.
  assign i_done  = m_load && ((i_kind_q != KIND_PAIR) || i_second_q);

  assign in_stall_o = i_valid_q && !i_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Position tracking and decode at acceptance
  // ---------------------------------------------------------------------------
  logic [RW-1:0]    row_q;
  logic [CW-1:0]    col_q;
  logic [CMP_W-1:0] row_ext, col_ext;
  logic             row_end, frame_end, col_zero, low_row, hold_even;
  kind_e            kind_in;

  assign row_ext   = CMP_W'(row_q);
  assign col_ext   = CMP_W'(col_q);
  assign row_end   = (col_ext + CMP_W'(1)) >= ncols;
  assign frame_end = row_end && ((row_ext + CMP_W'(1)) >= nrows);
  assign col_zero  = (col_ext == '0);
  assign low_row   = (row_ext < CMP_W'(2));
  assign hold_even = col_zero && !low_row && !row_q[0];

  always_comb begin
    if (col_zero && low_row) begin
      kind_in = KIND_REAL;
    end else if (col_zero) begin
      kind_in = KIND_PAIR;
    end else begin
      kind_in = KIND_CPLX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : RW'(row_ext + CMP_W'(1));
      end else begin
        col_q <= CW'(col_ext + CMP_W'(1));
      end
    end
  end

  // Even-row column-0 word: real parts, kept for the odd row that follows.
  in_beat_t held_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && hold_even) begin
      held_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Issue stage: one beat per clock, unless stalled from downstream, into the multipliers
  // ---------------------------------------------------------------------------
  in_beat_t         i_data_q;
  logic [POS_W-1:0] i_row_q, i_col_q;
  logic             i_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_valid_q  <= 1'b0;
      i_second_q <= 1'b0;
      i_kind_q   <= KIND_REAL;
    end else if (in_acc && !hold_even) begin
      i_valid_q  <= 1'b1;
      i_second_q <= 1'b0;
      i_kind_q   <= kind_in;
    end else if (i_done) begin
      i_valid_q  <= 1'b0;
      i_second_q <= 1'b0;
    end else if (m_load) begin
      // first half of a column-0 pair went out; issue the imaginary row next
      i_second_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !hold_even) begin
      i_data_q  <= in_data_i;
      i_row_q   <= row_ext[POS_W-1:0];
      i_col_q   <= col_ext[POS_W-1:0];
      i_frame_q <= frame_end;
    end
  end

  // Map the beat onto four products: slot0 = p0 +/- p1, slot1 = p2 +/- p3.
  logic signed [SAMPLE_W-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
  logic                       b_sub0, b_sub1, b_run, b_frame;
  logic [POS_W-1:0]           b_row;

  always_comb begin
    x0 = i_data_q.a_slot0;  y0 = i_data_q.b_slot0;
    x1 = i_data_q.a_slot1;  y1 = i_data_q.b_slot1;
    x2 = i_data_q.a_slot1;  y2 = i_data_q.b_slot0;
    x3 = i_data_q.a_slot0;  y3 = i_data_q.b_slot1;
    b_sub0  = !conj_q;
    b_sub1  = conj_q;
    b_run   = 1'b1;
    b_frame = i_frame_q;
    b_row   = i_row_q;
    case (i_kind_q)
      KIND_REAL: begin
        // slots stand alone; zero operands kill the cross terms
        x1 = '0;  y1 = '0;
        x2 = i_data_q.a_slot1;  y2 = i_data_q.b_slot1;
        x3 = '0;  y3 = '0;
      end
      KIND_CPLX: ;
      KIND_PAIR: begin
        if (!i_second_q) begin
          // real parts of both slots, reported on the even row
          x0 = held_q.a_slot0;    y0 = held_q.b_slot0;
          x1 = i_data_q.a_slot0;  y1 = i_data_q.b_slot0;
          x2 = held_q.a_slot1;    y2 = held_q.b_slot1;
          x3 = i_data_q.a_slot1;  y3 = i_data_q.b_slot1;
          b_sub1  = !conj_q;
          b_run   = 1'b0;
          b_frame = 1'b0;
          b_row   = i_row_q - POS_W'(1);
        end else begin
          // imaginary parts of both slots
          x0 = i_data_q.a_slot0;  y0 = held_q.b_slot0;
          x1 = held_q.a_slot0;    y1 = i_data_q.b_slot0;
          x2 = i_data_q.a_slot1;  y2 = held_q.b_slot1;
          x3 = held_q.a_slot1;    y3 = i_data_q.b_slot1;
          b_sub0  = conj_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Product stage
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p0, p1, p2, p3;
  logic                     m_sub0_q, m_sub1_q, m_run_q, m_frame_q;
  logic [POS_W-1:0]         m_row_q, m_col_q;

  pscm_prod_pair u_prod_slot0 (
    .clk_i (clk_i),
    .en_i  (m_load),
    .x0_i  (x0),
    .y0_i  (y0),
    .x1_i  (x1),
    .y1_i  (y1),
    .p0_o  (p0),
    .p1_o  (p1)
  );

  pscm_prod_pair u_prod_slot1 (
    .clk_i (clk_i),
    .en_i  (m_load),
    .x0_i  (x2),
    .y0_i  (y2),
    .x1_i  (x3),
    .y1_i  (y3),
    .p0_o  (p2),
    .p1_o  (p3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_load) begin
      m_valid_q <= 1'b1;
    end else if (o_load) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_sub0_q  <= b_sub0;
      m_sub1_q  <= b_sub1;
      m_run_q   <= b_run;
      m_frame_q <= b_frame;
      m_row_q   <= b_row;
      m_col_q   <= i_col_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum, saturate and hold the result beat
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum0, sum1;
  out_beat_t               o_data_d, o_data_q;

  assign sum0 = m_sub0_q ? (SUM_W'(p0) - SUM_W'(p1)) : (SUM_W'(p0) + SUM_W'(p1));
  assign sum1 = m_sub1_q ? (SUM_W'(p2) - SUM_W'(p3)) : (SUM_W'(p2) + SUM_W'(p3));

  always_comb begin
    o_data_d.c_slot0    = sat_sample(sum0);
    o_data_d.c_slot1    = sat_sample(sum1);
    o_data_d.out_row    = m_row_q;
    o_data_d.out_col    = m_col_q;
    o_data_d.run_last   = m_run_q;
    o_data_d.frame_last = m_frame_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_load) begin
      o_valid_q <= 1'b1;
    end else if (out_acc) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_data_q <= o_data_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic pair_first, frame_mid_run;

  assign pair_first    = i_valid_q && (i_kind_q == KIND_PAIR) && !i_second_q;
  assign frame_mid_run = o_data_q.frame_last && !o_data_q.run_last;

  `ASSERT_NEVER(a_col_range, col_ext >= CMP_W'(MAX_COLS), "column counter out of range")
  `ASSERT_NEVER(a_row_range, row_ext >= CMP_W'(MAX_ROWS), "row counter out of range")
  `ASSERT_NEVER(a_pair_block, in_acc && pair_first, "input taken mid pair")
  `ASSERT_NEVER(a_frame_run, o_valid_q && frame_mid_run, "frame end without run end")

endmodule

[test/packed_spectrum_complex_multiply_tb.sv]
module packed_spectrum_complex_multiply_tb;
  import pscm_pkg::*;

  // Mirror the block's default size limits.
  localparam int unsigned ROW_LIMIT = 1024;
  localparam int unsigned COL_LIMIT = 1024;
  // The block holds beats in its issue, product and result registers; give it a margin before touching registers.
  localparam int DRAIN_CYCLES = 8;
  // Cycles without any beat moving before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 400;
  localparam int RANDOM_BEATS = 560;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_beat_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_beat_t            out_data_o;

  packed_spectrum_complex_multiply dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers, raster position and the held column-0 word.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]           cols_cfg;
  logic [CFG_W-1:0]           rows_cfg;
  logic                       conj_cfg;
  int unsigned                row_pos;
  int unsigned                col_pos;
  logic signed [SAMPLE_W-1:0] held_a0, held_a1, held_b0, held_b1;

  out_beat_t pending_products[$];

  int fail_count;
  int beats_in;
  int beats_out;
  int spectra_done;
  int cfg_writes;
  int quiet_cycles;
  int tx_calm;
  int rx_calm;

  // Sample values that sit on the edges of Q1.30: -2.0, just under 2.0, zero,
  // one LSB below zero, +1.0 and -1.0.
  logic signed [SAMPLE_W-1:0] corner[6] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0,
                                             -32'sh1, 32'sh4000_0000, 32'shC000_0000};
  // Out-of-range and odd register values that exercise the clamping.
  logic [CFG_W-1:0] odd_cols[4] = '{11'd0, 11'd1, 11'd1025, 11'd2047};
  logic [CFG_W-1:0] odd_rows[4] = '{11'd0, 11'd1, 11'd3, 11'd2047};

  function automatic int unsigned eff_cols();
    int unsigned n;
    n = cols_cfg;
    if (n < 2) n = 2;
    if (n > COL_LIMIT) n = COL_LIMIT;
    return n;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned n;
    n = rows_cfg & ~32'd1;
    if (n < 2) n = 2;
    if (n > ROW_LIMIT) n = ROW_LIMIT;
    n = n & ~32'd1;
    if (n < 2) n = 2;
    return n;
  endfunction

  // Full product, then floor by 2^30 (arithmetic shift rounds toward minus infinity).
  function automatic longint floor_q30(input logic signed [SAMPLE_W-1:0] x,
                                       input logic signed [SAMPLE_W-1:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip_q30(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic void complex_mul(input logic signed [SAMPLE_W-1:0] ar, ai, br, bi,
                                      output logic signed [SAMPLE_W-1:0] re, im);
    if (conj_cfg) begin
      re = clip_q30(floor_q30(ar, br) + floor_q30(ai, bi));
      im = clip_q30(floor_q30(ai, br) - floor_q30(ar, bi));
    end else begin
      re = clip_q30(floor_q30(ar, br) - floor_q30(ai, bi));
      im = clip_q30(floor_q30(ai, br) + floor_q30(ar, bi));
    end
  endfunction

  function automatic out_beat_t make_product(input logic signed [SAMPLE_W-1:0] c0, c1,
                                             input int unsigned row, col,
                                             input logic run_end, frame_end);
    out_beat_t b;
    b.c_slot0    = c0;
    b.c_slot1    = c1;
    b.out_row    = row[POS_W-1:0];
    b.out_col    = col[POS_W-1:0];
    b.run_last   = run_end;
    b.frame_last = frame_end;
    return b;
  endfunction

  // Work out the product beats that one accepted input beat causes, then
  // advance the raster position.
  task automatic model_multiply(input in_beat_t w);
    logic                       row_end, frame_end;
    logic signed [SAMPLE_W-1:0] r0, i0, r1, i1;
    row_end   = (col_pos + 1 >= eff_cols());
    frame_end = row_end && (row_pos + 1 >= eff_rows());
    if (col_pos == 0 && row_pos < 2) begin
      // DC / Nyquist column: purely real, slots multiply on their own.
      pending_products.push_back(make_product(clip_q30(floor_q30(w.a_slot0, w.b_slot0)),
                                              clip_q30(floor_q30(w.a_slot1, w.b_slot1)),
                                              row_pos, 0, 1'b1, frame_end));
    end else if (col_pos == 0 && row_pos[0] == 1'b0) begin
      // Even row carries the real parts: hold, no product yet.
      held_a0 = w.a_slot0;
      held_a1 = w.a_slot1;
      held_b0 = w.b_slot0;
      held_b1 = w.b_slot1;
    end else if (col_pos == 0) begin
      // Odd row carries the imaginary parts: release real row, then this row.
      complex_mul(held_a0, w.a_slot0, held_b0, w.b_slot0, r0, i0);
      complex_mul(held_a1, w.a_slot1, held_b1, w.b_slot1, r1, i1);
      pending_products.push_back(make_product(r0, r1, row_pos - 1, 0, 1'b0, 1'b0));
      pending_products.push_back(make_product(i0, i1, row_pos, 0, 1'b1, frame_end));
    end else begin
      complex_mul(w.a_slot0, w.a_slot1, w.b_slot0, w.b_slot1, r0, i0);
      pending_products.push_back(make_product(r0, i0, row_pos, col_pos, 1'b1, frame_end));
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------

  // Draw an idle count of 0..7, with occasional calm stretches of no idling.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1:    return corner[$urandom_range(0, 5)];
      2:       return $signed(32'($urandom_range(0, 255))) - 32'sd128;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t random_word();
    in_beat_t w;
    w.a_slot0 = rand_sample();
    w.a_slot1 = rand_sample();
    w.b_slot0 = rand_sample();
    w.b_slot1 = rand_sample();
    return w;
  endfunction

  // Present one beat and wait for it to be taken. Valid is left high so that a
  // back-to-back beat does not drop and raise it in the same step.
  task automatic send_word(input in_beat_t w);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_in++;
    model_multiply(w);
  endtask

  // Drop valid, let every expected product come out, then idle for a margin; a
  // held beat (which has no product) stays in the held word and does not flow on.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive clocks; the enable stays high
  // across them and drops once.
  task automatic configure(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                           input logic conj);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_NUM_COLS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_idx_i  <= REG_NUM_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_idx_i  <= REG_CONJ;
    cfg_data_i <= CFG_W'(conj);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cols_cfg   = cols;
    rows_cfg   = rows;
    conj_cfg   = conj;
    cfg_writes += 3;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall after each taken beat, and the checker.
  // ---------------------------------------------------------------------------
  initial begin : out_stall_gen
    int hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) hold = draw_wait(rx_calm);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_products
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (pending_products.size() == 0) begin
        $error("unexpected product beat: row %0d col %0d", out_data_o.out_row,
               out_data_o.out_col);
        fail_count++;
      end else begin
        want = pending_products.pop_front();
        if (want.frame_last) spectra_done++;
        if (out_data_o.c_slot0 !== want.c_slot0) begin
          $error("c_slot0: expected %0d, got %0d", want.c_slot0, out_data_o.c_slot0);
          fail_count++;
        end
        if (out_data_o.c_slot1 !== want.c_slot1) begin
          $error("c_slot1: expected %0d, got %0d", want.c_slot1, out_data_o.c_slot1);
          fail_count++;
        end
        if (out_data_o.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_data_o.out_row);
          fail_count++;
        end
        if (out_data_o.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_data_o.out_col);
          fail_count++;
        end
        if (out_data_o.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, out_data_o.run_last);
          fail_count++;
        end
        if (out_data_o.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last,
                 out_data_o.frame_last);
          fail_count++;
        end
      end
    end
  end

  // Count clocks on which no beat moves on either side; bail out if stuck.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One 4x4 spectrum: DC/Nyquist words, complex columns, the held even row and
  // its odd partner, frame end. Samples walk the Q1.30 corners so that both
  // saturation limits and floor rounding of negative products show up.
  task automatic test_corner_spectrum();
    in_beat_t w;
    configure(11'd4, 11'd4, 1'b0);
    for (int k = 0; k < 16; k++) begin
      w.a_slot0 = corner[k % 6];
      w.a_slot1 = corner[(k + 1) % 6];
      w.b_slot0 = corner[(k * 5) % 6];
      w.b_slot1 = corner[(k * 5 + 1) % 6];
      send_word(w);
    end
    settle();
  endtask

  // Same walk in conjugate mode on the narrowest legal spectrum: 2 columns, 4 rows.
  task automatic test_conjugate_spectrum();
    in_beat_t w;
    configure(11'd2, 11'd4, 1'b1);
    for (int k = 0; k < 8; k++) begin
      w.a_slot0 = corner[(k + 3) % 6];
      w.a_slot1 = corner[k % 6];
      w.b_slot0 = corner[(k * 5 + 2) % 6];
      w.b_slot1 = corner[(k + 4) % 6];
      send_word(w);
    end
    settle();
  endtask

  // Many small spectra with random contents and sizes, some with register values
  // out of range. Phases may stop mid-spectrum; the next setting then carries
  // on from the position the block stands at.
  task automatic test_random_spectra();
    int               sent;
    int               n;
    int unsigned      area;
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] r;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      c = ($urandom_range(0, 5) == 0) ? odd_cols[$urandom_range(0, 3)]
                                      : CFG_W'($urandom_range(2, 8));
      r = ($urandom_range(0, 5) == 0) ? odd_rows[$urandom_range(0, 3)]
                                      : CFG_W'($urandom_range(2, 10));
      configure(c, r, 1'($urandom_range(0, 1)));
      area = eff_cols() * eff_rows();
      n = area * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, area - 1);
      if (n > 120) n = 120;
      repeat (n) send_word(random_word());
      sent += n;
      settle();
    end
  endtask

  // Widest row setting for a stretch, then a narrow width mid-row to close that
  // row fast, then the tallest setting for a run of rows.
  task automatic test_size_extremes();
    configure(11'd1024, 11'd2, 1'b0);
    repeat (100) send_word(random_word());
    settle();
    configure(11'd2, 11'd2, 1'b1);
    repeat (2) send_word(random_word());
    settle();
    configure(11'd2, 11'd2047, 1'b0);
    repeat (100) send_word(random_word());
    settle();
  endtask

  initial begin : run
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_NUM_COLS;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cols_cfg   = 11'd1024;
    rows_cfg   = 11'd1024;
    conj_cfg   = 1'b0;
    row_pos    = 0;
    col_pos    = 0;
    held_a0    = '0;
    held_a1    = '0;
    held_b0    = '0;
    held_b1    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_spectrum();
    test_conjugate_spectrum();
    test_random_spectra();
    test_size_extremes();
    settle();

    $display("Covered %0d input beats and %0d product beats over %0d complete spectra,",
             beats_in, beats_out, spectra_done);
    $display("with %0d register writes spanning clamped, minimal and maximal sizes.",
             cfg_writes);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
